FILE: hw/rtl/llt_pkg.sv
package llt_pkg;

    localparam int LAT_W  = 24;
    localparam int LON_W  = 25;
    localparam int ZOOM_W = 5;
    localparam int XY_W   = 39;
    localparam int SH_W   = 6;
    localparam int PROD_W = 56;
    localparam int XM_W   = 51;
    localparam int Q_W    = 20;
    localparam int R_W    = 6;
    localparam int ANG_W  = 34;
    localparam int LOG_W  = 37;

    localparam logic [LAT_W-1:0]   LAT_LIMIT        = 24'd5573910;
    localparam logic [LON_W-1:0]   LON_HALF         = 25'd11796480;
    localparam logic [31:0]        ALPHA_SCALE      = 32'd2398762259;
    localparam logic [25:0]        DIV45_RECIP      = 26'd47721859;
    localparam int                 LON_DIV          = 45;
    localparam logic [ANG_W-1:0]   QUARTER_PI_Q30   = 34'd843314857;
    localparam logic [28:0]        LN2_OVER_2PI_Q32 = 29'd473811343;
    localparam logic [35:0]        L_MAG_LIMIT      = 36'h8_0000_0000;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
        30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
        30'h00000000, 30'h00000000
    };

    typedef struct packed {
        logic [PROD_W-1:0] alpha_prod;
        logic [XM_W-1:0]   lon_prod;
        logic [LON_W-1:0]  lon_u;
        logic              lat_neg;
        logic              clamp;
        logic              north;
        logic [SH_W-1:0]   sh;
    } llt_item_t;

    typedef struct packed {
        logic            clamp;
        logic            north;
        logic [SH_W-1:0] sh;
        logic [XY_W-1:0] tx;
    } llt_side_t;

    // floor(r * 2^k / 45), bit by bit long division on constants
    function automatic logic [63:0] div45_frac(input int r, input int k);
        logic [63:0] res;
        int          rem;
        res = '0;
        rem = r;
        for (int i = 0; i < 64; i++)
        begin
            if (i < k)
            begin
                rem = rem * 2;
                res = {res[62:0], 1'b0};
                if (rem >= LON_DIV)
                begin
                    res[0] = 1'b1;
                    rem    = rem - LON_DIV;
                end
            end
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/latlon_to_map_tile.sv
// channel   | ports                               | handshake
// ----------+-------------------------------------+-----------------------------------
// request   | latitude, longitude                 | taken at clk edge with start & !busy
// result    | tile_x, tile_y, lat_clamped         | done high for one cycle, no stall
// config    | cfg_data (zoom_level)               | written at clk edge with cfg_we
//
// one request per cycle sustained; each result passes through the back end pipeline
// (unrolled cordic plus the log2 squaring chain)
// rst_n clears the queue, pipeline valid bits and zoom_level (to 0)
// busy is the queue-full flag; the back end drains every cycle so it stays low
// the result side has no stall: done pulses once per request
module latlon_to_map_tile #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_ZOOM     = 22,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [llt_pkg::LAT_W-1:0]  latitude,
    input  logic signed [llt_pkg::LON_W-1:0]  longitude,
    input  logic                              cfg_we,
    input  logic [llt_pkg::ZOOM_W-1:0]        cfg_data,
    output logic                              done,
    output logic [llt_pkg::XY_W-1:0]          tile_x,
    output logic [llt_pkg::XY_W-1:0]          tile_y,
    output logic                              lat_clamped
);

    // zoom register; to be rewritten only while idle, which the block does not enforce
    logic [llt_pkg::ZOOM_W-1:0] zoom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            zoom_reg <= '0;
        else if (cfg_we)
            zoom_reg <= cfg_data;
    end

    // front end: classify latitude, saturate longitude, clamp zoom, launch multiplies
    llt_pkg::llt_item_t front_item;
    llt_pkg::llt_item_t head_item;
    logic               q_full;
    logic               head_valid;
    logic               push;

    assign push = start && !q_full;
    assign busy = q_full;

    llt_front #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_ZOOM  (MAX_ZOOM)
    ) u_front (
        .latitude  (latitude),
        .longitude (longitude),
        .zoom      (zoom_reg),
        .item      (front_item)
    );

    // short queue decoupling request side from the compute pipeline
    llt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop_valid (head_valid),
        .pop_item  (head_item)
    );

    // back end: tile x divide, cordic, log2 pair, final scaling
    llt_back #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_ZOOM     (MAX_ZOOM),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (head_valid),
        .in_item     (head_item),
        .done        (done),
        .tile_x      (tile_x),
        .tile_y      (tile_y),
        .lat_clamped (lat_clamped)
    );

endmodule

FILE: hw/rtl/llt_front.sv
module llt_front #(
    parameter int FRAC_BITS = 16,
    parameter int MAX_ZOOM  = 22
) (
    input  logic signed [llt_pkg::LAT_W-1:0]  latitude,
    input  logic signed [llt_pkg::LON_W-1:0]  longitude,
    input  logic [llt_pkg::ZOOM_W-1:0]        zoom,
    output llt_pkg::llt_item_t                item
);

    logic [llt_pkg::LAT_W-1:0]        lat_mag;
    logic                             lat_neg;
    logic signed [llt_pkg::LON_W-1:0] lon_sat;
    logic [llt_pkg::LON_W-1:0]        lon_u;
    logic [llt_pkg::ZOOM_W-1:0]       zoom_eff;

    always_comb
    begin
        lat_neg = latitude[llt_pkg::LAT_W-1];
        lat_mag = lat_neg ? llt_pkg::LAT_W'(-latitude) : llt_pkg::LAT_W'(latitude);

        // saturate longitude to +-180 degrees
        if (longitude > $signed(llt_pkg::LON_HALF))
            lon_sat = $signed(llt_pkg::LON_HALF);
        else if (longitude < -$signed(llt_pkg::LON_HALF))
            lon_sat = -$signed(llt_pkg::LON_HALF);
        else
            lon_sat = longitude;
        lon_u = llt_pkg::LON_W'(lon_sat + $signed(llt_pkg::LON_HALF));

        zoom_eff = (zoom > llt_pkg::ZOOM_W'(MAX_ZOOM)) ? llt_pkg::ZOOM_W'(MAX_ZOOM) : zoom;

        item.alpha_prod = llt_pkg::PROD_W'(lat_mag) * llt_pkg::PROD_W'(llt_pkg::ALPHA_SCALE);
        item.lon_prod   = llt_pkg::XM_W'(lon_u) * llt_pkg::XM_W'(llt_pkg::DIV45_RECIP);
        item.lon_u      = lon_u;
        item.lat_neg    = lat_neg;
        item.clamp      = lat_mag > llt_pkg::LAT_LIMIT;
        item.north      = !lat_neg;
        item.sh         = llt_pkg::SH_W'(zoom_eff) + llt_pkg::SH_W'(FRAC_BITS);
    end

endmodule

FILE: hw/rtl/llt_queue.sv
module llt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  llt_pkg::llt_item_t push_item,
    output logic               full,
    output logic               pop_valid,
    output llt_pkg::llt_item_t pop_item
);

    llt_pkg::llt_item_t mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               pop;

    // back end never stalls, so the head leaves whenever present
    assign pop       = count_reg != 2'd0;
    assign full      = count_reg == 2'd2;
    assign pop_valid = pop;
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: hw/rtl/llt_log2.sv
module llt_log2 (
    input  logic                       clk,
    input  logic [31:0]                v,
    output logic [llt_pkg::LOG_W-1:0]  lg
);

    localparam int STEPS = 32;

    logic [31:0] v_reg;
    logic [4:0]  p_reg;
    logic [4:0]  p_next;
    logic [30:0] m0_reg;
    logic [4:0]  p0_reg;

    logic [30:0] m_reg [STEPS];
    logic [31:0] f_reg [STEPS];
    logic [4:0]  pp_reg [STEPS];

    // leading one position
    always_comb
    begin
        p_next = 5'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (v[b])
                p_next = 5'(b);
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg  <= v;
        p_reg  <= p_next;
        p0_reg <= p_reg;
        if (p_reg >= 5'd30)
            m0_reg <= 31'(v_reg >> (p_reg - 5'd30));
        else
            m0_reg <= 31'(v_reg << (5'd30 - p_reg));
    end

    // one squaring per stage yields one fraction bit
    for (genvar k = 0; k < STEPS; k++)
    begin : g_sq
        logic [30:0] m_in;
        logic [31:0] f_in;
        logic [4:0]  p_in;
        logic [61:0] sq;
        logic [31:0] m2;

        if (k == 0)
        begin : g_first
            assign m_in = m0_reg;
            assign f_in = 32'd0;
            assign p_in = p0_reg;
        end
        else
        begin : g_rest
            assign m_in = m_reg[k-1];
            assign f_in = f_reg[k-1];
            assign p_in = pp_reg[k-1];
        end

        assign sq = 62'(m_in) * 62'(m_in);
        assign m2 = sq[61:30];

        always_ff @(posedge clk)
        begin
            pp_reg[k] <= p_in;
            if (m2[31])
            begin
                m_reg[k] <= m2[31:1];
                f_reg[k] <= f_in | (32'd1 << (31 - k));
            end
            else
            begin
                m_reg[k] <= m2[30:0];
                f_reg[k] <= f_in;
            end
        end
    end

    assign lg = {pp_reg[STEPS-1], f_reg[STEPS-1]};

endmodule

FILE: hw/rtl/llt_back.sv
module llt_back #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_ZOOM     = 22,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  llt_pkg::llt_item_t         in_item,
    output logic                       done,
    output logic [llt_pkg::XY_W-1:0]   tile_x,
    output logic [llt_pkg::XY_W-1:0]   tile_y,
    output logic                       lat_clamped
);

    localparam int SH_MAX    = MAX_ZOOM + FRAC_BITS;
    localparam int N         = CORDIC_STEPS;
    localparam int LOG_LAT   = 34;
    localparam int SIDE_LAST = N + LOG_LAT + 2;
    localparam int VLD_LAST  = SIDE_LAST + 1;
    localparam int AW        = llt_pkg::ANG_W;

    logic                        vld_reg [VLD_LAST+1];
    llt_pkg::llt_side_t          side_reg [SIDE_LAST+1];

    // stage 0: angle and longitude quotient
    logic signed [AW-1:0]        ang0_reg;
    logic [llt_pkg::Q_W-1:0]     q0_reg;
    logic [llt_pkg::R_W-1:0]     r0_reg;
    logic [56:0]                 d_sum;
    logic [32:0]                 d_val;
    logic [llt_pkg::Q_W-1:0]     q_est;
    logic [25:0]                 r_full;

    always_comb
    begin
        d_sum  = 57'(in_item.alpha_prod) + 57'(1 << 23);
        d_val  = d_sum[56:24];
        q_est  = in_item.lon_prod[llt_pkg::XM_W-1:31];
        r_full = 26'(in_item.lon_u) - 26'(q_est) * 26'(llt_pkg::LON_DIV);
    end

    always_ff @(posedge clk)
    begin
        if (in_item.lat_neg)
            ang0_reg <= $signed(llt_pkg::QUARTER_PI_Q30 - AW'(d_val));
        else
            ang0_reg <= $signed(llt_pkg::QUARTER_PI_Q30 + AW'(d_val));
        q0_reg      <= q_est;
        r0_reg      <= r_full[llt_pkg::R_W-1:0];
        side_reg[0] <= '{clamp: in_item.clamp, north: in_item.north,
                         sh: in_item.sh, tx: '0};
    end

    // stage 1: tile x from quotient and remainder fraction table
    logic [63:0]  xtab [llt_pkg::LON_DIV];
    logic [71:0]  xq;
    logic [71:0]  xq_sh;
    logic [6:0]   x_amt;

    for (genvar r = 0; r < llt_pkg::LON_DIV; r++)
    begin : g_xtab
        localparam logic [63:0] XV = llt_pkg::div45_frac(r, SH_MAX);
        assign xtab[r] = XV;
    end

    always_comb
    begin
        xq    = (72'(q0_reg) << SH_MAX) + 72'(xtab[r0_reg]);
        x_amt = 7'(SH_MAX + 19) - 7'(side_reg[0].sh);
        xq_sh = xq >> x_amt;
    end

    always_ff @(posedge clk)
    begin
        side_reg[1] <= '{clamp: side_reg[0].clamp, north: side_reg[0].north,
                         sh: side_reg[0].sh, tx: xq_sh[llt_pkg::XY_W-1:0]};
    end

    for (genvar k = 2; k <= SIDE_LAST; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_reg[k-1];
        end
    end

    // cordic rotation, one micro-rotation per stage
    logic signed [AW-1:0] cx_w [N+1];
    logic signed [AW-1:0] cy_w [N+1];
    logic signed [AW-1:0] ca_w [N+1];
    logic signed [AW-1:0] cx_reg [N];
    logic signed [AW-1:0] cy_reg [N];
    logic signed [AW-1:0] ca_reg [N];

    assign cx_w[0] = AW'(1 << 29);
    assign cy_w[0] = '0;
    assign ca_w[0] = ang0_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (!ca_w[i][AW-1])
            begin
                cx_reg[i] <= cx_w[i] - (cy_w[i] >>> i);
                cy_reg[i] <= cy_w[i] + (cx_w[i] >>> i);
                ca_reg[i] <= ca_w[i] - $signed(AW'(llt_pkg::ATAN_Q30[i]));
            end
            else
            begin
                cx_reg[i] <= cx_w[i] + (cy_w[i] >>> i);
                cy_reg[i] <= cy_w[i] - (cx_w[i] >>> i);
                ca_reg[i] <= ca_w[i] + $signed(AW'(llt_pkg::ATAN_Q30[i]));
            end
        end
        assign cx_w[i+1] = cx_reg[i];
        assign cy_w[i+1] = cy_reg[i];
        assign ca_w[i+1] = ca_reg[i];
    end

    // non-positive sine or cosine is taken as one
    logic [31:0] vx;
    logic [31:0] vy;
    assign vx = (cx_w[N] > 0) ? cx_w[N][31:0] : 32'd1;
    assign vy = (cy_w[N] > 0) ? cy_w[N][31:0] : 32'd1;

    logic [llt_pkg::LOG_W-1:0] lgx;
    logic [llt_pkg::LOG_W-1:0] lgy;

    llt_log2 u_log_x (.clk(clk), .v(vx), .lg(lgx));
    llt_log2 u_log_y (.clk(clk), .v(vy), .lg(lgy));

    // log difference, magnitude limit, scale by ln2/2pi
    logic [37:0] diff;
    logic [37:0] diff_mag;
    logic [35:0] lmag_reg;
    logic        lneg_reg;
    logic [64:0] prod_full;
    logic [63:0] prod_reg;
    logic        lneg2_reg;

    always_comb
    begin
        diff      = 38'(lgy) - 38'(lgx);
        diff_mag  = diff[37] ? -diff : diff;
        prod_full = 65'(lmag_reg) * 65'(llt_pkg::LN2_OVER_2PI_Q32);
    end

    always_ff @(posedge clk)
    begin
        lneg_reg  <= diff[37];
        lmag_reg  <= (diff_mag > 38'(llt_pkg::L_MAG_LIMIT)) ? llt_pkg::L_MAG_LIMIT
                                                           : diff_mag[35:0];
        prod_reg  <= prod_full[64:1];
        lneg2_reg <= lneg_reg;
    end

    // final: offset from the equator, scale to grid, edge clamps
    llt_pkg::llt_side_t side_f;
    logic [64:0]        t_sum;
    logic [63:0]        t_val;
    logic [63:0]        ty_m;
    logic [63:0]        ty;

    always_comb
    begin
        side_f = side_reg[SIDE_LAST];
        if (!lneg2_reg)
        begin
            t_sum = '0;
            t_val = (prod_reg >= (64'd1 << 62)) ? 64'd0 : (64'd1 << 62) - prod_reg;
        end
        else
        begin
            t_sum = 65'(64'd1 << 62) + 65'(prod_reg);
            t_val = (t_sum > 65'(64'd1 << 63)) ? (64'd1 << 63) : t_sum[63:0];
        end
        ty_m = t_val >> (6'd63 - side_f.sh);
        if (side_f.clamp)
            ty = side_f.north ? 64'd0 : (64'd1 << side_f.sh);
        else
            ty = ty_m;
    end

    logic [llt_pkg::XY_W-1:0] tile_x_reg;
    logic [llt_pkg::XY_W-1:0] tile_y_reg;
    logic                     clamp_reg;

    always_ff @(posedge clk)
    begin
        tile_x_reg <= side_f.tx;
        tile_y_reg <= ty[llt_pkg::XY_W-1:0];
        clamp_reg  <= side_f.clamp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= VLD_LAST; k++)
                vld_reg[k] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= VLD_LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign done        = vld_reg[VLD_LAST];
    assign tile_x      = tile_x_reg;
    assign tile_y      = tile_y_reg;
    assign lat_clamped = clamp_reg;

endmodule

FILE: hw/rtl/llt_checker.sv
module llt_checker #(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_ZOOM     = 22,
    parameter int CORDIC_STEPS = 24
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [llt_pkg::XY_W-1:0]        tile_x,
    input logic [llt_pkg::XY_W-1:0]        tile_y,
    input logic                            lat_clamped
);

    localparam int LAT    = CORDIC_STEPS + 39;
    localparam int SH_MAX = MAX_ZOOM + FRAC_BITS;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after fixed latency");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !busy)
        else $error("queue did not drain");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (64'(tile_x) <= (64'd1 << SH_MAX)))
        else $error("tile_x beyond grid");

    a_clamp_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (done && lat_clamped) |-> (tile_y == '0 || $onehot(tile_y)))
        else $error("clamped tile_y not at a grid edge");

endmodule

bind latlon_to_map_tile llt_checker #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_ZOOM     (MAX_ZOOM),
    .CORDIC_STEPS (CORDIC_STEPS)
) u_llt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .lat_clamped (lat_clamped)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_ZOOM     = 22;
    localparam int CORDIC_STEPS = 24;
    // result latency of the top level, from request to done
    localparam int LATENCY      = CORDIC_STEPS + 38;
    localparam int IDLE_LIMIT   = 5000;
    localparam int LAT_MAX      = 5898240;
    localparam int LON_MAX      = 11796480;

    typedef struct {
        logic [llt_pkg::XY_W-1:0] x;
        logic [llt_pkg::XY_W-1:0] y;
        logic                     clamped;
    } tile_t;

    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic signed [llt_pkg::LAT_W-1:0]  latitude;
    logic signed [llt_pkg::LON_W-1:0]  longitude;
    logic                              cfg_we;
    logic [llt_pkg::ZOOM_W-1:0]        cfg_data;
    logic                              done;
    logic [llt_pkg::XY_W-1:0]          tile_x;
    logic [llt_pkg::XY_W-1:0]          tile_y;
    logic                              lat_clamped;

    // testbench copy of the zoom register
    logic [llt_pkg::ZOOM_W-1:0] zoom_shadow;
    tile_t                      pending_tiles[$];
    int                         error_count = 0;
    int                         idle_cycles = 0;

    latlon_to_map_tile #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_ZOOM     (MAX_ZOOM),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .latitude    (latitude),
        .longitude   (longitude),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .tile_x      (tile_x),
        .tile_y      (tile_y),
        .lat_clamped (lat_clamped)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ---------------------------------------------------------------
    // tile predictor
    // ---------------------------------------------------------------

    // log2 as unsigned Q32 by normalize and repeated squaring
    function automatic longint unsigned log2_fixed(input longint unsigned v);
        int                p;
        longint unsigned   m;
        longint unsigned   frac;
        p    = 0;
        frac = 0;
        if (v == 0)
            v = 1;
        while (p < 63 && (v >> (p + 1)) != 0)
            p++;
        m = (p >= 30) ? (v >> (p - 30)) : (v << (30 - p));
        for (int k = 0; k < 32; k++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | (64'd1 << (31 - k));
            end
        end
        return (longint'(p) << 32) | frac;
    endfunction

    // y in Q63 of the grid, shifted down to zoom + fraction bits
    function automatic longint unsigned mercator_row(input longint lat, input int sh);
        longint unsigned mag;
        longint unsigned d;
        longint          ang;
        longint          cx;
        longint          cy;
        longint          nx;
        longint          lg;
        longint unsigned lmag;
        longint unsigned prod;
        longint unsigned t;
        mag = (lat < 0) ? longint'(-lat) : longint'(lat);
        d   = (mag * 64'd2398762259 + (64'd1 << 23)) >> 24;
        ang = (lat < 0) ? 64'sd843314857 - longint'(d) : 64'sd843314857 + longint'(d);
        cx  = 64'sd1 << 29;
        cy  = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (ang >= 0)
            begin
                nx  = cx - (cy >>> (i % 32));
                cy  = cy + (cx >>> (i % 32));
                ang = ang - longint'(llt_pkg::ATAN_Q30[i % 32]);
            end
            else
            begin
                nx  = cx + (cy >>> (i % 32));
                cy  = cy - (cx >>> (i % 32));
                ang = ang + longint'(llt_pkg::ATAN_Q30[i % 32]);
            end
            cx = nx;
        end
        // degenerate rotation output taken as 1
        if (cx <= 0)
            cx = 1;
        if (cy <= 0)
            cy = 1;
        lg   = longint'(log2_fixed(cy)) - longint'(log2_fixed(cx));
        lmag = (lg < 0) ? longint'(-lg) : longint'(lg);
        if (lmag > (64'd1 << 35))
            lmag = 64'd1 << 35;
        prod = (lmag * 64'd473811343) >> 1;
        if (lg >= 0)
            t = (prod >= (64'd1 << 62)) ? 64'd0 : (64'd1 << 62) - prod;
        else
        begin
            t = (64'd1 << 62) + prod;
            if (t > (64'd1 << 63))
                t = 64'd1 << 63;
        end
        return t >> (63 - sh);
    endfunction

    function automatic tile_t predict_tile(input logic signed [llt_pkg::LAT_W-1:0] lat_in,
                                           input logic signed [llt_pkg::LON_W-1:0] lon_in);
        tile_t           r;
        int              zoom;
        int              sh;
        longint          lat;
        longint          lon;
        longint unsigned lon_u;
        longint unsigned tx;
        longint unsigned ty;
        zoom = (zoom_shadow > MAX_ZOOM) ? MAX_ZOOM : int'(zoom_shadow);
        sh   = zoom + FRAC_BITS;
        lat  = lat_in;
        lon  = lon_in;
        r.clamped = 1'b0;
        // longitude saturates at the antimeridian
        if (lon > LON_MAX)
            lon = LON_MAX;
        if (lon < -LON_MAX)
            lon = -LON_MAX;
        lon_u = lon + LON_MAX;
        // full circle is 45 * 2^19 input units
        if (sh >= 19)
            tx = (lon_u << (sh - 19)) / 45;
        else
            tx = (lon_u >> (19 - sh)) / 45;
        if (lat > longint'(llt_pkg::LAT_LIMIT))
        begin
            r.clamped = 1'b1;
            ty = 0;
        end
        else if (lat < -longint'(llt_pkg::LAT_LIMIT))
        begin
            r.clamped = 1'b1;
            ty = 64'd1 << sh;
        end
        else
            ty = mercator_row(lat, sh);
        r.x = tx[llt_pkg::XY_W-1:0];
        r.y = ty[llt_pkg::XY_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result checker: done cannot be stalled, so every pulse is a result
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        tile_t want;
        if (rst_n && done)
        begin
            if (pending_tiles.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_tiles.pop_front();
                if (tile_x !== want.x)
                begin
                    $error("tile_x expected %0d actual %0d", want.x, tile_x);
                    error_count++;
                end
                if (tile_y !== want.y)
                begin
                    $error("tile_y expected %0d actual %0d", want.y, tile_y);
                    error_count++;
                end
                if (lat_clamped !== want.clamped)
                begin
                    $error("lat_clamped expected %0d actual %0d", want.clamped,
                           lat_clamped);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request taken and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // shared drivers
    // ---------------------------------------------------------------

    // one request with a random lead-in gap; start stays high on return
    task automatic send_request(input logic signed [llt_pkg::LAT_W-1:0] lat,
                                input logic signed [llt_pkg::LON_W-1:0] lon);
        int gap;
        gap = $urandom_range(0, 9);
        // at least a third of requests go back to back
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        latitude  <= lat;
        longitude <= lon;
        // busy only moves at rising edges, so it is steady here
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_tiles.insert(pending_tiles.size(), predict_tile(lat, lon));
        @(negedge clk);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results;
        start <= 1'b0;
        while (pending_tiles.size() != 0)
            @(negedge clk);
    endtask

    // zoom is only written with the pipeline empty
    task automatic write_zoom(input logic [llt_pkg::ZOOM_W-1:0] zoom);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= zoom;
        @(negedge clk);
        cfg_we      <= 1'b0;
        zoom_shadow = zoom;
    endtask

    task automatic send_random_request;
        logic signed [llt_pkg::LAT_W-1:0] lat;
        logic signed [llt_pkg::LON_W-1:0] lon;
        int                               pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            // raw bit patterns, often out of range
            lat = llt_pkg::LAT_W'($urandom);
            lon = llt_pkg::LON_W'($urandom);
        end
        else if (pick == 1)
        begin
            // hug the mercator limit
            lat = llt_pkg::LAT_W'(int'(llt_pkg::LAT_LIMIT) - 8 + int'($urandom_range(0, 16)));
            if ($urandom_range(0, 1))
                lat = -lat;
            lon = llt_pkg::LON_W'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
        end
        else
        begin
            lat = llt_pkg::LAT_W'(int'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
            lon = llt_pkg::LON_W'(int'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
        end
        send_request(lat, lon);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // field extremes, limit edges and longitude saturation at zoom 0
    task automatic test_extremes;
        write_zoom(5'd0);
        send_request(24'sd0, 25'sd0);
        send_request(llt_pkg::LAT_W'(LAT_MAX), llt_pkg::LON_W'(LON_MAX));
        send_request(llt_pkg::LAT_W'(-LAT_MAX), llt_pkg::LON_W'(-LON_MAX));
        send_request(llt_pkg::LAT_LIMIT, 25'sd1);
        send_request(-llt_pkg::LAT_LIMIT, -25'sd1);
        send_request(llt_pkg::LAT_LIMIT + 24'd1, llt_pkg::LON_W'(LON_MAX - 1));
        send_request(-llt_pkg::LAT_LIMIT - 24'd1, llt_pkg::LON_W'(-LON_MAX + 1));
        send_request(24'sh7FFFFF, 25'shFFFFFF);
        send_request(24'sh800000, 25'sh1000000);
        send_request(24'sh555555, 25'sh0AAAAAA);
        send_request(24'shAAAAAA, 25'sh1555555);
        send_request(24'sd1, llt_pkg::LON_W'(LON_MAX + 1));
        send_request(-24'sd1, llt_pkg::LON_W'(-LON_MAX - 1));
    endtask

    // grid edge zooms, including values above the maximum
    task automatic test_zoom_range;
        logic [llt_pkg::ZOOM_W-1:0] zooms[5];
        zooms = '{5'd22, 5'd23, 5'd31, 5'd1, 5'd18};
        foreach (zooms[i])
        begin
            write_zoom(zooms[i]);
            send_request(llt_pkg::LAT_W'(LAT_MAX), llt_pkg::LON_W'(LON_MAX));
            send_request(llt_pkg::LAT_W'(-LAT_MAX), llt_pkg::LON_W'(-LON_MAX));
            send_request(llt_pkg::LAT_LIMIT, 25'sd0);
            send_request(-llt_pkg::LAT_LIMIT, 25'sd0);
            send_random_request();
        end
    endtask

    // random traffic across a set of zoom settings, draining mid-phase and before each zoom write
    task automatic test_random_traffic;
        for (int phase = 0; phase < 10; phase++)
        begin
            write_zoom((phase % 3 == 0) ? 5'($urandom) : 5'($urandom_range(0, MAX_ZOOM)));
            for (int n = 0; n < 50; n++)
            begin
                send_random_request();
                if (n == 25)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        latitude    = '0;
        longitude   = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        zoom_shadow = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset zoom must hold before the first write
        send_request(24'sd1000000, 25'sd2000000);
        test_extremes();
        test_zoom_range();
        test_random_traffic();

        drain_results();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/llt_pkg.sv
hw/rtl/llt_front.sv
hw/rtl/llt_queue.sv
hw/rtl/llt_log2.sv
hw/rtl/llt_back.sv
hw/rtl/latlon_to_map_tile.sv
hw/rtl/llt_checker.sv
sim/tb_top.sv
